// ----- design/fat32_cluster_chain_reader_top_macros.svh -----
// Assertion macros used by the cluster chain reader controller.
`ifndef FAT32_CLUSTER_CHAIN_READER_TOP_MACROS_SVH
`define FAT32_CLUSTER_CHAIN_READER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FCCR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FCCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/fccr_pkg.sv -----
// Types and constants shared by the cluster chain reader modules.
`timescale 1ns / 1ps

package fccr_pkg;

    localparam int unsigned MaxClusterBytes = 524288;
    localparam logic [27:0] ClusterMask = 28'hFFFFFFF;
    localparam logic [19:0] FatEntryBytes = 20'd4;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_REPLY = 2'd1,
        OP_FAIL  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_FAT   = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CFG_BYTES_PER_SECTOR    = 3'd0,
        CFG_SECTORS_PER_CLUSTER = 3'd1,
        CFG_RESERVED_SECTORS    = 3'd2,
        CFG_FAT_COUNT           = 3'd3,
        CFG_FAT_SECTORS         = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_WALK,
        S_DATA,
        S_NEXT,
        S_OUT_FIN,
        S_OUT_ERR
    } state_t;

    typedef struct packed {
        logic capture;
        logic start_init;
        logic load_reply;
        logic emit_data;
        logic emit_fat;
        logic emit_fin;
        logic emit_err;
    } fccr_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       is_dir;
        logic       len_zero;
        logic       at_eoc;
        logic       more;
        logic       out_free;
    } fccr_sts_t;

endpackage

// ----- design/fccr_datapath.sv -----
// Datapath: configuration, walk state, address arithmetic and result register.
`timescale 1ns / 1ps

module fccr_datapath #(
    parameter int unsigned END_OF_CHAIN = 268435448
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [1:0]          s_tuser,
    input  logic [127:0]        s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [135:0]        m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast,
    input  fccr_pkg::fccr_cmd_t cmd,
    output fccr_pkg::fccr_sts_t sts
);
    import fccr_pkg::*;

    localparam logic [27:0] EocValue = 28'(END_OF_CHAIN);

    // configuration
    logic [12:0] bps_reg;
    logic [7:0]  spc_reg;
    logic [15:0] res_reg;
    logic [7:0]  fcnt_reg;
    logic [31:0] fsec_reg;

    // captured request
    logic [1:0]  op_reg;
    logic [27:0] start_reg;
    logic [31:0] fsize_reg;
    logic [31:0] maxlen_reg;
    logic        dir_reg;
    logic [31:0] fatval_reg;

    // walk state
    logic [27:0] cluster_reg, cluster_next;
    logic [31:0] done_reg, done_next;
    logic [31:0] wanted_reg, wanted_next;

    // arithmetic stages
    logic [39:0] pfat_reg;
    logic [47:0] pclus_reg;
    logic [20:0] csz_full_reg;
    logic [28:0] fatbase_reg;
    logic [47:0] sum_reg;
    logic [19:0] csz_reg;
    logic [47:0] fataddr_reg;
    logic [47:0] daddr_reg;

    // result register
    logic        vld_reg;
    logic [1:0]  kind_reg;
    logic [47:0] addr_reg;
    logic [19:0] len_reg;
    logic [31:0] off_reg;
    logic [31:0] total_reg;
    logic        last_reg;

    logic [31:0] min_len;
    logic [31:0] remaining;
    logic [19:0] chunk;
    logic [47:0] clus_m2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bps_reg  <= 13'd512;
            spc_reg  <= 8'd1;
            res_reg  <= 16'd32;
            fcnt_reg <= 8'd2;
            fsec_reg <= 32'd1;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_BYTES_PER_SECTOR:    bps_reg  <= cfg_data[12:0];
                CFG_SECTORS_PER_CLUSTER: spc_reg  <= cfg_data[7:0];
                CFG_RESERVED_SECTORS:    res_reg  <= cfg_data[15:0];
                CFG_FAT_COUNT:           fcnt_reg <= cfg_data[7:0];
                CFG_FAT_SECTORS:         fsec_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= s_tuser;
            start_reg  <= s_tdata[27:0];
            fsize_reg  <= s_tdata[59:28];
            maxlen_reg <= s_tdata[91:60];
            dir_reg    <= s_tdata[92];
            fatval_reg <= s_tdata[124:93];
        end
    end

    assign min_len   = (fsize_reg < maxlen_reg) ? fsize_reg : maxlen_reg;
    assign remaining = wanted_reg - done_reg;
    assign chunk     = ({12'd0, csz_reg} < remaining) ? csz_reg : remaining[19:0];

    always_comb begin
        cluster_next = cluster_reg;
        done_next    = done_reg;
        wanted_next  = wanted_reg;
        if (cmd.start_init) begin
            done_next    = '0;
            wanted_next  = dir_reg ? '0 : min_len;
            cluster_next = (dir_reg || (min_len == '0)) ? '0 : start_reg;
        end else if (cmd.load_reply) begin
            cluster_next = fatval_reg[27:0] & ClusterMask;
        end else if (cmd.emit_data) begin
            done_next = done_reg + {12'd0, chunk};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cluster_reg <= '0;
            done_reg    <= '0;
            wanted_reg  <= '0;
        end else begin
            cluster_reg <= cluster_next;
            done_reg    <= done_next;
            wanted_reg  <= wanted_next;
        end
    end

    // Three register stages; the controller waits until the address is through.
    assign clus_m2 = {20'd0, cluster_reg} - 48'd2;

    always_ff @(posedge aclk) begin
        pfat_reg     <= 40'(fcnt_reg) * 40'(fsec_reg);
        pclus_reg    <= clus_m2 * 48'(spc_reg);
        csz_full_reg <= 21'(bps_reg) * 21'(spc_reg);
        fatbase_reg  <= 29'(res_reg) * 29'(bps_reg);

        sum_reg     <= 48'(res_reg) + 48'(pfat_reg) + pclus_reg;
        csz_reg     <= (32'(csz_full_reg) > MaxClusterBytes)
                       ? 20'(MaxClusterBytes) : csz_full_reg[19:0];
        fataddr_reg <= 48'(fatbase_reg) + {18'd0, cluster_reg, 2'b00};

        daddr_reg <= sum_reg * 48'(bps_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (cmd.emit_data || cmd.emit_fat || cmd.emit_fin || cmd.emit_err) begin
            vld_reg <= 1'b1;
        end else if (m_tready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_data) begin
            kind_reg  <= KIND_DATA;
            addr_reg  <= daddr_reg;
            len_reg   <= chunk;
            off_reg   <= done_reg;
            total_reg <= done_reg + {12'd0, chunk};
            last_reg  <= 1'b0;
        end else if (cmd.emit_fat) begin
            kind_reg  <= KIND_FAT;
            addr_reg  <= fataddr_reg;
            len_reg   <= FatEntryBytes;
            off_reg   <= '0;
            total_reg <= done_reg;
            last_reg  <= 1'b1;
        end else if (cmd.emit_fin || cmd.emit_err) begin
            kind_reg  <= cmd.emit_err ? KIND_ERROR : KIND_DONE;
            addr_reg  <= '0;
            len_reg   <= '0;
            off_reg   <= '0;
            total_reg <= done_reg;
            last_reg  <= 1'b1;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'd0, total_reg, off_reg, len_reg, addr_reg};

    assign sts.op       = op_reg;
    assign sts.is_dir   = dir_reg;
    assign sts.len_zero = (min_len == '0);
    assign sts.at_eoc   = (cluster_reg >= EocValue);
    assign sts.more     = (done_reg < wanted_reg);
    assign sts.out_free = !vld_reg || m_tready;

endmodule

// ----- design/fccr_ctrl.sv -----
// Controller state machine that sequences one request through the datapath.
`timescale 1ns / 1ps

module fccr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  fccr_pkg::fccr_sts_t sts,
    output fccr_pkg::fccr_cmd_t cmd
);
    import fccr_pkg::*;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        busy_next  = busy_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.op)
                    OP_START: begin
                        cmd.start_init = 1'b1;
                        busy_next      = 1'b0;
                        if (sts.is_dir) begin
                            state_next = S_OUT_ERR;
                        end else if (sts.len_zero) begin
                            state_next = S_OUT_FIN;
                        end else begin
                            state_next = S_MUL1;
                        end
                    end
                    OP_REPLY: begin
                        if (busy_reg) begin
                            cmd.load_reply = 1'b1;
                            state_next     = S_MUL1;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end
                    OP_FAIL: begin
                        busy_next  = 1'b0;
                        state_next = S_OUT_ERR;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_MUL3;
            S_MUL3: state_next = S_WALK;
            S_WALK: begin
                if (sts.at_eoc) begin
                    busy_next  = 1'b0;
                    state_next = S_OUT_FIN;
                end else begin
                    state_next = S_DATA;
                end
            end
            S_DATA: begin
                if (sts.out_free) begin
                    cmd.emit_data = 1'b1;
                    state_next    = S_NEXT;
                end
            end
            S_NEXT: begin
                if (!sts.more) begin
                    busy_next  = 1'b0;
                    state_next = S_OUT_FIN;
                end else if (sts.out_free) begin
                    cmd.emit_fat = 1'b1;
                    busy_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_OUT_FIN: begin
                if (sts.out_free) begin
                    cmd.emit_fin = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_OUT_ERR: begin
                if (sts.out_free) begin
                    cmd.emit_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

`include "fat32_cluster_chain_reader_top_macros.svh"

    `FCCR_ASSERT_NEXT(a_accept_decodes, s_tvalid && s_tready, state_reg == S_DECODE, "accepted request not decoded")
    `FCCR_ASSERT_NOW(a_emit_needs_slot, cmd.emit_data || cmd.emit_fat || cmd.emit_fin || cmd.emit_err, sts.out_free, "result issued over an unread result")
    `FCCR_ASSERT_NOW(a_data_below_eoc, cmd.emit_data, !sts.at_eoc, "data read issued at end of chain")
    `FCCR_ASSERT_NEXT(a_busy_only_on_fat, !busy_reg && !cmd.emit_fat, !busy_reg, "busy set without a FAT entry request")

endmodule

// ----- design/fat32_cluster_chain_reader_top.sv -----
// Top level of the FAT32 cluster chain reader: ports, controller and datapath.
`timescale 1ns / 1ps

// The block walks the cluster chain of one FAT32 file. Volume geometry is held
// in five registers written over the cfg_* channel (index 0 bytes per sector,
// 1 sectors per cluster, 2 reserved sectors, 3 FAT count, 4 sectors per FAT),
// which may only be written while the block is idle. A start request names
// the first cluster, file size, buffer limit and directory bit; for each
// cluster the block issues a data read request clipped to the bytes still
// wanted, then either a FAT entry read request (whose reply, op 1, carries the
// next cluster) or a finished result with the byte total. A directory, or a
// storage failure request (op 2), gives an error result. Requests are handled
// one at a time: a request is taken, then decoded in the next cycle; a start
// or reply that reaches a cluster then passes through the registered address
// multipliers and the end-of-chain check. A cluster past the end of the chain
// then gives a finished result; otherwise the data read request follows, then
// the FAT entry read request, or a finished result when no bytes are still
// wanted, each once the result side is ready; directory, empty-length,
// failure and ignored requests go from decode to a result or back to idle.
// The result register lets a new request in while the last result of the
// previous one still waits to be taken.
// Addresses are byte addresses, 48 bits wide, wrapping at that width.
module fat32_cluster_chain_reader_top #(
    parameter int unsigned END_OF_CHAIN = 268435448
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    // input requests
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // start_cluster[27:0], fsize[59:28],
                                    // max_len[91:60], is_directory[92],
                                    // fat_value[124:93], zero[127:125]
    input  logic [1:0]   s_tuser,   // op[1:0]
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // address[47:0], length[67:48],
                                    // buffer_offset[99:68], total_bytes[131:100],
                                    // zero[135:132]
    output logic [1:0]   m_tuser,   // kind[1:0]
    output logic         m_tlast    // last result caused by a request
);
    import fccr_pkg::*;

    fccr_cmd_t cmd;
    fccr_sts_t sts;

    // Registers are plain flip-flops, so every write is taken at once.
    assign cfg_ready = 1'b1;

    fccr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fccr_datapath #(
        .END_OF_CHAIN (END_OF_CHAIN)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
